/* src/kgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgb_pkg
// Shared widths, register indexes and reset values of the angle and gyro
// bias Kalman filter.
// ----------------------------------------------------------------------------
package kgb_pkg;

    // Field and register widths.
    localparam int FIELD_W   = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_COV  = 28;

    // Default width of the stored state.
    localparam int DATA_WIDTH_DEF = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd3;

    // Register reset values, unsigned Q3.28.
    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = 31'd268435;
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = 31'd805306;
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = 31'd134217728;
    localparam logic [CFG_W-1:0] RST_PERIOD      = 31'd2684355;

endpackage

/* src/kgb_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgb_in_if
// Sample request channel: accelerometer angle and gyro rate.
// ----------------------------------------------------------------------------
interface kgb_in_if
    import kgb_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] angle_meas;
    logic signed [FIELD_W-1:0] gyro_rate;

    modport source (output valid, output angle_meas, output gyro_rate, input ready);
    modport sink   (input valid, input angle_meas, input gyro_rate, output ready);
endinterface

/* src/kgb_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgb_out_if
// Result request channel: filtered angle and bias-corrected rate.
// ----------------------------------------------------------------------------
interface kgb_out_if
    import kgb_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] angle_est;
    logic signed [FIELD_W-1:0] rate_est;

    modport source (output valid, output angle_est, output rate_est, input ready);
    modport sink   (input valid, input angle_est, input rate_est, output ready);
endinterface

/* src/kgb_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgb_mul
// Shared fixed-point multiplier. Computes floor(a * b / 2^28) clamped to
// +-2^62 with one 32x32 multiplier used for two partial products.
// ----------------------------------------------------------------------------
module kgb_mul
    import kgb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LO   = 3'd1;
    localparam logic [2:0] PH_HI   = 3'd2;
    localparam logic [2:0] PH_ACC  = 3'd3;
    localparam logic [2:0] PH_RND  = 3'd4;
    localparam logic [67:0] LIM    = 68'd1 << 62;

    logic [2:0]         r_ph;
    logic               r_neg;
    logic [63:0]        r_ua;
    logic [31:0]        r_ub;
    logic [63:0]        r_pp;
    logic [95:0]        r_acc;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [31:0] w_half;
    logic [63:0] w_prod;
    logic [67:0] w_q;
    logic [67:0] w_qc;

    // One partial product per cycle: low half first, then high half.
    assign w_half = (r_ph == PH_LO) ? r_ua[31:0] : r_ua[63:32];
    assign w_prod = w_half * r_ub;

    // Round the result toward minus infinity (magnitude rounded up when negative), then clamp.
    assign w_q  = r_acc[95:FRAC_COV] + {67'd0, r_neg & (|r_acc[FRAC_COV-1:0])};
    assign w_qc = (w_q > LIM) ? LIM : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_ph <= PH_LO;
                    end
                end
                PH_LO:   r_ph <= PH_HI;
                PH_HI:   r_ph <= PH_ACC;
                PH_ACC:  r_ph <= PH_RND;
                PH_RND: begin
                    r_ph   <= PH_IDLE;
                    r_done <= 1'b1;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_ph == PH_IDLE && i_start) begin
            r_neg <= i_a[63] ^ i_b[31];
            r_ua  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub  <= i_b[31] ? 32'(-i_b) : 32'(i_b);
        end
        if (r_ph == PH_LO) begin
            r_pp <= w_prod;
        end
        if (r_ph == PH_HI) begin
            r_acc <= {32'd0, r_pp};
            r_pp  <= w_prod;
        end
        if (r_ph == PH_ACC) begin
            r_acc <= r_acc + {r_pp, 32'd0};
        end
        if (r_ph == PH_RND) begin
            r_res <= r_neg ? -$signed(w_qc[63:0]) : $signed(w_qc[63:0]);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* src/kgb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgb_div
// Restoring divider for the gains: trunc(n * 2^28 / d) for d > 0, one
// quotient bit a cycle, saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module kgb_div
    import kgb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_n,
    input  logic signed [63:0] i_d,
    output logic               o_done,
    output logic signed [31:0] o_q
);

    localparam int QB = 31;

    logic              r_run;
    logic [4:0]        r_cnt;
    logic              r_neg;
    logic              r_ov;
    logic [63:0]       r_d;
    logic [63:0]       r_rem;
    logic [QB-1:0]     r_nb;
    logic [QB-1:0]     r_q;
    logic              r_done;
    logic signed [31:0] r_out;

    logic [63:0] w_un;
    logic [63:0] w_trial;
    logic        w_ge;

    assign w_un    = i_n[63] ? 64'(-i_n) : 64'(i_n);
    assign w_trial = {r_rem[62:0], r_nb[QB-1]};
    assign w_ge    = (w_trial >= r_d);

    // Step counter and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_run && i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'(QB);
            end else if (r_run && r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
            end else if (r_run) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (!r_run && i_start) begin
            r_neg <= i_n[63];
            r_d   <= i_d;
            r_rem <= w_un >> 3;
            r_nb  <= {w_un[2:0], 28'd0};
            r_ov  <= (w_un >= (i_d << 3));
            r_q   <= '0;
        end else if (r_run && r_cnt != 5'd0) begin
            r_rem <= w_ge ? (w_trial - r_d) : w_trial;
            r_nb  <= {r_nb[QB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], w_ge};
        end else if (r_run) begin
            // Integer part of eight or more saturates.
            if (r_ov) begin
                r_out <= r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_out <= r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_out;

endmodule

/* src/angle_gyro_bias_kalman_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter_unit
// Two-state tilt Kalman filter (angle, gyro bias) run by a sequencer over one
// shared multiplier and one shared divider.
//
//   Channel   Dir  Handshake          Payload
//   i_in      in   valid / ready      angle_meas, gyro_rate (Q16.16)
//   o_out     out  valid / ready      angle_est, rate_est (Q16.16)
//   i_cfg_*   in   write enable only  register index, 31-bit data
//
// A sample runs from its accept through ten multiplies on the shared
// multiplier and two divides on the shared divider to the load of the
// result. When the innovation variance is not positive the divides are
// skipped. The next sample is accepted only after the result is loaded.
// Reset is synchronous and active low and restores the registers and state.
// A result waits in the output register while the next sample is accepted;
// the finished sample stalls only if that register is still full.
// ----------------------------------------------------------------------------
module angle_gyro_bias_kalman_filter_unit
    import kgb_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kgb_in_if.sink               i_in,
    kgb_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int W = DATA_WIDTH;
    localparam logic signed [65:0] HI_W  = (66'sd1 <<< (W - 1)) - 66'sd1;
    localparam logic signed [65:0] LO_W  = -HI_W - 66'sd1;
    localparam logic signed [65:0] HI_32 = 66'sd2147483647;
    localparam logic signed [65:0] LO_32 = -66'sd2147483648;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PA   = 4'd1;
    localparam logic [3:0] S_PD00 = 4'd2;
    localparam logic [3:0] S_PD11 = 4'd3;
    localparam logic [3:0] S_PQ11 = 4'd4;
    localparam logic [3:0] S_DV0  = 4'd5;
    localparam logic [3:0] S_DV1  = 4'd6;
    localparam logic [3:0] S_C10  = 4'd7;
    localparam logic [3:0] S_C00  = 4'd8;
    localparam logic [3:0] S_C11  = 4'd9;
    localparam logic [3:0] S_C01  = 4'd10;
    localparam logic [3:0] S_UA   = 4'd11;
    localparam logic [3:0] S_UB   = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    function automatic logic signed [W-1:0] sat_w(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v > HI_W) ? HI_W : ((v < LO_W) ? LO_W : v);
        return r[W-1:0];
    endfunction

    function automatic logic signed [31:0] sat_32(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v > HI_32) ? HI_32 : ((v < LO_32) ? LO_32 : v);
        return r[31:0];
    endfunction

    localparam logic signed [W-1:0] P_ONE = sat_w(66'sd1 <<< FRAC_COV);

    // Configuration registers.
    logic [CFG_W-1:0] r_apn, r_bpn, r_mn, r_dt;

    // Filter state and per-sample working registers.
    logic signed [W-1:0]  r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0]   r_k0, r_k1;
    logic signed [31:0]   r_meas, r_gyro;
    logic [3:0]           r_state;
    logic                 r_busy;
    logic                 r_ovalid;
    logic signed [31:0]   r_oangle, r_orate;

    logic                 w_mul_start, w_mul_done;
    logic signed [63:0]   w_mul_a, w_mul_res;
    logic signed [31:0]   w_mul_b;
    logic                 w_div_start, w_div_done;
    logic signed [63:0]   w_div_n, w_e;
    logic signed [31:0]   w_div_q;
    logic                 w_mul_state;
    logic                 w_e_pos;
    logic signed [65:0]   w_res66;
    logic signed [63:0]   w_err;
    logic                 w_load;

    assign w_e     = 64'(signed'({1'b0, r_mn})) + 64'(r_p00);
    assign w_e_pos = (w_e > 64'sd0);
    assign w_err   = 64'(r_meas) - 64'(r_angle);
    assign w_res66 = 66'(w_mul_res);
    assign w_load  = (r_state == S_FIN) && (!r_ovalid || o_out.ready);

    assign w_mul_state = (r_state == S_PA)  || (r_state == S_PD00) ||
                         (r_state == S_PD11) || (r_state == S_PQ11) ||
                         (r_state == S_C10) || (r_state == S_C00) ||
                         (r_state == S_C11) || (r_state == S_C01) ||
                         (r_state == S_UA)  || (r_state == S_UB);
    assign w_mul_start = w_mul_state && !r_busy;
    assign w_div_start = !r_busy &&
                         (((r_state == S_DV0) && w_e_pos) || (r_state == S_DV1));
    assign w_div_n     = (r_state == S_DV0) ? 64'(r_p00) : 64'(r_p10);

    // Operand selection for the shared multiplier. The bias is corrected
    // before the angle so that both corrections use the predicted angle.
    always_comb begin
        w_mul_a = 64'(r_p00);
        w_mul_b = signed'({1'b0, r_dt});
        unique case (r_state)
            S_PA:    w_mul_a = 64'(r_gyro) - 64'(r_bias);
            S_PD00:  w_mul_a = 64'(signed'({1'b0, r_apn})) - 64'(r_p01) - 64'(r_p10);
            S_PD11:  w_mul_a = 64'(r_p11);
            S_PQ11:  w_mul_a = 64'(signed'({1'b0, r_bpn}));
            S_C10:   w_mul_b = r_k1;
            S_C00:   w_mul_b = r_k0;
            S_C11: begin
                w_mul_a = 64'(r_p01);
                w_mul_b = r_k1;
            end
            S_C01: begin
                w_mul_a = 64'(r_p01);
                w_mul_b = r_k0;
            end
            S_UA: begin
                w_mul_a = w_err;
                w_mul_b = r_k1;
            end
            S_UB: begin
                w_mul_a = w_err;
                w_mul_b = r_k0;
            end
            default: ;
        endcase
    end

    kgb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    kgb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_div_n),
        .i_d     (w_e),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn <= RST_ANGLE_NOISE;
            r_bpn <= RST_BIAS_NOISE;
            r_mn  <= RST_MEAS_NOISE;
            r_dt  <= RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ANGLE_NOISE: r_apn <= i_cfg_data;
                REG_BIAS_NOISE:  r_bpn <= i_cfg_data;
                REG_MEAS_NOISE:  r_mn  <= i_cfg_data;
                REG_PERIOD:      r_dt  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_angle  <= '0;
            r_bias   <= '0;
            r_p00    <= P_ONE;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= P_ONE;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_mul_start || w_div_start) begin
                r_busy <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_meas  <= i_in.angle_meas;
                        r_gyro  <= i_in.gyro_rate;
                        r_state <= S_PA;
                    end
                end
                S_DV0: begin
                    if (!r_busy && !w_e_pos) begin
                        r_k0    <= '0;
                        r_k1    <= '0;
                        r_state <= S_C10;
                    end else if (r_busy && w_div_done) begin
                        r_busy  <= 1'b0;
                        r_k0    <= w_div_q;
                        r_state <= S_DV1;
                    end
                end
                S_DV1: begin
                    if (r_busy && w_div_done) begin
                        r_busy  <= 1'b0;
                        r_k1    <= w_div_q;
                        r_state <= S_C10;
                    end
                end
                S_FIN: begin
                    // Load the result once the output register is free.
                    if (w_load) begin
                        r_oangle <= sat_32(66'(r_angle));
                        r_orate  <= sat_32(66'(r_gyro) - 66'(r_bias));
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    if (w_mul_state && r_busy && w_mul_done) begin
                        r_busy  <= 1'b0;
                        r_state <= r_state + 4'd1;
                        unique case (r_state)
                            S_PA:   r_angle <= sat_w(66'(r_angle) + w_res66);
                            S_PD00: r_p00   <= sat_w(66'(r_p00) + w_res66);
                            S_PD11: begin
                                r_p01 <= sat_w(66'(r_p01) - w_res66);
                                r_p10 <= sat_w(66'(r_p10) - w_res66);
                            end
                            S_PQ11: r_p11   <= sat_w(66'(r_p11) + w_res66);
                            S_C10:  r_p10   <= sat_w(66'(r_p10) - w_res66);
                            S_C00:  r_p00   <= sat_w(66'(r_p00) - w_res66);
                            S_C11:  r_p11   <= sat_w(66'(r_p11) - w_res66);
                            S_C01:  r_p01   <= sat_w(66'(r_p01) - w_res66);
                            S_UA:   r_bias  <= sat_w(66'(r_bias) + w_res66);
                            S_UB:   r_angle <= sat_w(66'(r_angle) + w_res66);
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.angle_est = r_oangle;
    assign o_out.rate_est  = r_orate;

    // An accepted request always starts the prediction.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == S_PA)
        else $error("accepted request did not start the prediction");

    // The multiplier and the divider are never started together.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_start && w_div_start))
        else $error("multiplier and divider started in the same cycle");

    // A finished sample always lands in the output register.
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && (!r_ovalid || o_out.ready) |=> o_out.valid)
        else $error("finished sample not presented");

endmodule
